@@ sv/hsv2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Widths, constants and hue sector codes shared by the hsv to rgb converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   localparam int HueWidth   = 9;
   localparam int PctWidth   = 7;
   localparam int LevelWidth = 8;
   localparam int FracWidth  = 6;

   localparam logic [HueWidth-1:0] HueTurn  = 9'd360;
   localparam logic [PctWidth-1:0] PctFull  = 7'd100;
   localparam logic [HueWidth-1:0] Sector1  = 9'd60;
   localparam logic [HueWidth-1:0] Sector2  = 9'd120;
   localparam logic [HueWidth-1:0] Sector3  = 9'd180;
   localparam logic [HueWidth-1:0] Sector4  = 9'd240;
   localparam logic [HueWidth-1:0] Sector5  = 9'd300;

   // floor(n/100) = (n*20972) >> 21 for n up to 2^15
   localparam logic [14:0] Recip100      = 15'd20972;
   localparam int          Recip100Shift = 21;
   // floor(n/60) = (n*17477) >> 20 for n up to 2^14
   localparam logic [14:0] Recip60       = 15'd17477;
   localparam int          Recip60Shift  = 20;

   typedef enum logic [2:0] {
      SecRedYellow   = 3'd0,
      SecYellowGreen = 3'd1,
      SecGreenCyan   = 3'd2,
      SecCyanBlue    = 3'd3,
      SecBlueMagenta = 3'd4,
      SecMagentaRed  = 3'd5
   } sector_type;

endpackage

@@ sv/hsv_to_rgb_converter_core.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// Integer hsv to 8-bit rgb conversion in an eight stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one pixel per beat: hue in degrees (taken modulo
//   360), saturation and value in percent (above 100 read as 100).
//   rsp_ channel returns the matching 8-bit red, green and blue, one beat
//   per request beat, in order.
//   One pixel is taken every cycle while the receiver keeps rsp_tready high;
//   each constant-reciprocal multiplier is given its own stage.
//   When rsp_tready is low with a result waiting, the whole pipeline holds
//   and req_tready drops in the same cycle; nothing is lost or repeated.
//   Stages: hue reduce and clamp, sector split and v*255, top level,
//   top*(100-s), bottom level, ramp product, ramp scale, channel select.
//   Reset clears every stage valid bit; no other state is kept.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core
   import hsv2rgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // hue[8:0], saturation[15:9], brightness[22:16], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // red[7:0], green[15:8], blue[23:16]
);

   localparam int Stages = 8;

   logic                  adv;
   logic [Stages-1:0]     vld_ff;
   logic [Stages-1:0]     vld_in;

   logic [HueWidth-1:0]   hue;
   logic [PctWidth-1:0]   sat;
   logic [PctWidth-1:0]   bright;

   // stage 1
   logic [HueWidth-1:0]   s1_hue_ff, s1_hue_in;
   logic [PctWidth-1:0]   s1_sat_ff, s1_sat_in;
   logic [PctWidth-1:0]   s1_val_ff, s1_val_in;
   // stage 2
   sector_type            s2_sec_ff, s2_sec_in;
   logic [FracWidth-1:0]  s2_frac_ff, s2_frac_in;
   logic [14:0]           s2_vs_ff, s2_vs_in;
   logic [PctWidth-1:0]   s2_sinv_ff, s2_sinv_in;
   logic [HueWidth-1:0]   s2_base;
   // stage 3
   sector_type            s3_sec_ff;
   logic [FracWidth-1:0]  s3_frac_ff;
   logic [PctWidth-1:0]   s3_sinv_ff;
   logic [LevelWidth-1:0] s3_top_ff, s3_top_in;
   logic [29:0]           s3_prod;
   // stage 4
   sector_type            s4_sec_ff;
   logic [FracWidth-1:0]  s4_frac_ff;
   logic [LevelWidth-1:0] s4_top_ff;
   logic [14:0]           s4_bp_ff, s4_bp_in;
   // stage 5
   sector_type            s5_sec_ff;
   logic [FracWidth-1:0]  s5_frac_ff;
   logic [LevelWidth-1:0] s5_top_ff;
   logic [LevelWidth-1:0] s5_bot_ff, s5_bot_in;
   logic [29:0]           s5_prod;
   // stage 6
   sector_type            s6_sec_ff;
   logic [LevelWidth-1:0] s6_top_ff;
   logic [LevelWidth-1:0] s6_bot_ff;
   logic [13:0]           s6_rp_ff, s6_rp_in;
   // stage 7
   sector_type            s7_sec_ff;
   logic [LevelWidth-1:0] s7_top_ff;
   logic [LevelWidth-1:0] s7_bot_ff;
   logic [LevelWidth-1:0] s7_ramp_ff, s7_ramp_in;
   logic [28:0]           s7_prod;
   // stage 8 (output register)
   logic [LevelWidth-1:0] s8_r_ff, s8_r_in;
   logic [LevelWidth-1:0] s8_g_ff, s8_g_in;
   logic [LevelWidth-1:0] s8_b_ff, s8_b_in;
   logic [LevelWidth-1:0] rise;
   logic [LevelWidth-1:0] fall;

   assign adv        = !vld_ff[Stages-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[Stages-1];
   assign rsp_tdata  = {s8_b_ff, s8_g_ff, s8_r_ff};

   assign hue    = req_tdata[8:0];
   assign sat    = req_tdata[15:9];
   assign bright = req_tdata[22:16];

   assign vld_in = {vld_ff[Stages-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: hue reduce and percent clamp
   always_comb begin
      s1_hue_in = (hue >= HueTurn) ? hue - HueTurn : hue;
      s1_sat_in = (sat > PctFull) ? PctFull : sat;
      s1_val_in = (bright > PctFull) ? PctFull : bright;
   end

   // stage 2: sector split, v*255 as shift and subtract
   always_comb begin
      if (s1_hue_ff >= Sector5) begin
         s2_sec_in = SecMagentaRed;
         s2_base   = Sector5;
      end else if (s1_hue_ff >= Sector4) begin
         s2_sec_in = SecBlueMagenta;
         s2_base   = Sector4;
      end else if (s1_hue_ff >= Sector3) begin
         s2_sec_in = SecCyanBlue;
         s2_base   = Sector3;
      end else if (s1_hue_ff >= Sector2) begin
         s2_sec_in = SecGreenCyan;
         s2_base   = Sector2;
      end else if (s1_hue_ff >= Sector1) begin
         s2_sec_in = SecYellowGreen;
         s2_base   = Sector1;
      end else begin
         s2_sec_in = SecRedYellow;
         s2_base   = '0;
      end
      s2_frac_in = FracWidth'(s1_hue_ff - s2_base);
      s2_vs_in   = {s1_val_ff, 8'd0} - {8'd0, s1_val_ff};
      s2_sinv_in = PctFull - s1_sat_ff;
   end

   // stage 3: top = floor(v*255/100)
   assign s3_prod   = s2_vs_ff * Recip100;
   assign s3_top_in = s3_prod[Recip100Shift +: LevelWidth];

   // stage 4: top*(100-s)
   assign s4_bp_in = s3_top_ff * s3_sinv_ff;

   // stage 5: bottom = floor(top*(100-s)/100)
   assign s5_prod   = s4_bp_ff * Recip100;
   assign s5_bot_in = s5_prod[Recip100Shift +: LevelWidth];

   // stage 6: (top-bottom)*frac
   assign s6_rp_in = (s5_top_ff - s5_bot_ff) * s5_frac_ff;

   // stage 7: ramp = floor(product/60)
   assign s7_prod    = s6_rp_ff * Recip60;
   assign s7_ramp_in = s7_prod[Recip60Shift +: LevelWidth];

   // stage 8: channel select
   assign rise = s7_bot_ff + s7_ramp_ff;
   assign fall = s7_top_ff - s7_ramp_ff;

   always_comb begin
      case (s7_sec_ff)
         SecRedYellow: begin
            s8_r_in = s7_top_ff;
            s8_g_in = rise;
            s8_b_in = s7_bot_ff;
         end
         SecYellowGreen: begin
            s8_r_in = fall;
            s8_g_in = s7_top_ff;
            s8_b_in = s7_bot_ff;
         end
         SecGreenCyan: begin
            s8_r_in = s7_bot_ff;
            s8_g_in = s7_top_ff;
            s8_b_in = rise;
         end
         SecCyanBlue: begin
            s8_r_in = s7_bot_ff;
            s8_g_in = fall;
            s8_b_in = s7_top_ff;
         end
         SecBlueMagenta: begin
            s8_r_in = rise;
            s8_g_in = s7_bot_ff;
            s8_b_in = s7_top_ff;
         end
         default: begin
            s8_r_in = s7_top_ff;
            s8_g_in = s7_bot_ff;
            s8_b_in = fall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_hue_ff  <= s1_hue_in;
         s1_sat_ff  <= s1_sat_in;
         s1_val_ff  <= s1_val_in;

         s2_sec_ff  <= s2_sec_in;
         s2_frac_ff <= s2_frac_in;
         s2_vs_ff   <= s2_vs_in;
         s2_sinv_ff <= s2_sinv_in;

         s3_sec_ff  <= s2_sec_ff;
         s3_frac_ff <= s2_frac_ff;
         s3_sinv_ff <= s2_sinv_ff;
         s3_top_ff  <= s3_top_in;

         s4_sec_ff  <= s3_sec_ff;
         s4_frac_ff <= s3_frac_ff;
         s4_top_ff  <= s3_top_ff;
         s4_bp_ff   <= s4_bp_in;

         s5_sec_ff  <= s4_sec_ff;
         s5_frac_ff <= s4_frac_ff;
         s5_top_ff  <= s4_top_ff;
         s5_bot_ff  <= s5_bot_in;

         s6_sec_ff  <= s5_sec_ff;
         s6_top_ff  <= s5_top_ff;
         s6_bot_ff  <= s5_bot_ff;
         s6_rp_ff   <= s6_rp_in;

         s7_sec_ff  <= s6_sec_ff;
         s7_top_ff  <= s6_top_ff;
         s7_bot_ff  <= s6_bot_ff;
         s7_ramp_ff <= s7_ramp_in;

         s8_r_ff    <= s8_r_in;
         s8_g_ff    <= s8_g_in;
         s8_b_ff    <= s8_b_in;
      end
   end

endmodule

@@ tb/tb_hsv_to_rgb_converter_core.sv @@
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter_core
// Self-checking bench for the hsv to rgb pipeline: corner pixels from a
// table, a long output stall with a full drain, then random pixels, all
// scored in order against table colours or a behavioural colour calculation.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter_core
   import hsv2rgb_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned HueDegTurn  = 360;
   localparam int unsigned SectorDeg   = 60;
   localparam int unsigned PctMax      = 100;
   localparam int unsigned LevelMax    = 255;
   localparam int          ResetCycles = 6;
   localparam int          HoldCycles  = 80;
   localparam int          DrainCycles = 24;
   localparam int          CycleLimit  = 200000;
   localparam int          CornerRows  = 23;
   localparam int          StallItems  = 40;
   localparam int          RandomItems = 540;
   localparam int          QuietItems  = 64;

   typedef struct packed {
      logic [LevelWidth-1:0] blue;
      logic [LevelWidth-1:0] green;
      logic [LevelWidth-1:0] red;
   } rgb_type;

   typedef struct packed {
      logic [HueWidth-1:0] hue;
      logic [PctWidth-1:0] sat;
      logic [PctWidth-1:0] bri;
      logic                typed;
      rgb_type             rgb;
   } corner_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // hue[8:0], saturation[15:9], brightness[22:16], zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // red[7:0], green[15:8], blue[23:16]

   rgb_type        pending_rgb[$];
   corner_row_type corner_rows [CornerRows];
   int             pixels_sent;
   int             pixels_checked;
   int             mismatch_count;
   int             cycle_count;
   bit             sender_idling;
   bit             receiver_idling;
   bit             hold_output;

   hsv_to_rgb_converter_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // integer hsv to rgb, all divisions truncating
   function automatic rgb_type rgb_of_hsv(logic [HueWidth-1:0] hue_in,
                                          logic [PctWidth-1:0] sat_in,
                                          logic [PctWidth-1:0] bri_in);
      int unsigned           hue, sat, bri, top, bot, frac, ramp;
      logic [LevelWidth-1:0] hi, lo, up, down;
      sector_type            sector;
      rgb_type               colour;
      hue    = hue_in % HueDegTurn;
      sat    = (sat_in > PctMax) ? PctMax : sat_in;
      bri    = (bri_in > PctMax) ? PctMax : bri_in;
      top    = bri * LevelMax / PctMax;
      bot    = top * (PctMax - sat) / PctMax;
      sector = sector_type'(hue / SectorDeg);
      frac   = hue % SectorDeg;
      ramp   = (top - bot) * frac / SectorDeg;
      hi     = LevelWidth'(top);
      lo     = LevelWidth'(bot);
      up     = LevelWidth'(bot + ramp);
      down   = LevelWidth'(top - ramp);
      case (sector)
         SecRedYellow: begin
            colour.red = hi;   colour.green = up;   colour.blue = lo;
         end
         SecYellowGreen: begin
            colour.red = down; colour.green = hi;   colour.blue = lo;
         end
         SecGreenCyan: begin
            colour.red = lo;   colour.green = hi;   colour.blue = up;
         end
         SecCyanBlue: begin
            colour.red = lo;   colour.green = down; colour.blue = hi;
         end
         SecBlueMagenta: begin
            colour.red = up;   colour.green = lo;   colour.blue = hi;
         end
         default: begin
            colour.red = hi;   colour.green = lo;   colour.blue = down;
         end
      endcase
      return colour;
   endfunction

   // drive one pixel from a falling edge, return at the falling edge after its beat
   task automatic send_pixel(input logic [HueWidth-1:0] hue, input logic [PctWidth-1:0] sat,
                             input logic [PctWidth-1:0] bri, input bit typed,
                             input rgb_type typed_rgb);
      if (sender_idling && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, bri, sat, hue};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_rgb.push_back(typed ? typed_rgb : rgb_of_hsv(hue, sat, bri));
      pixels_sent++;
      @(negedge clock);
   endtask

   // mostly in-range percentages, with the saturating band now and then
   task automatic send_random_pixel();
      logic [PctWidth-1:0] sat;
      logic [PctWidth-1:0] bri;
      sat = ($urandom_range(0, 6) == 0) ? PctWidth'($urandom_range(0, 127))
                                        : PctWidth'($urandom_range(0, 100));
      bri = ($urandom_range(0, 6) == 0) ? PctWidth'($urandom_range(0, 127))
                                        : PctWidth'($urandom_range(0, 100));
      send_pixel(HueWidth'($urandom_range(0, 511)), sat, bri, 1'b0, '0);
   endtask

   // result checker
   always @(posedge clock) begin
      rgb_type want;
      rgb_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_rgb.size() == 0) begin
            $display("%0t: unexpected result beat rgb=%h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_rgb.pop_front();
            pixels_checked++;
            if (got.red !== want.red) begin
               $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
               mismatch_count++;
            end
            if (got.green !== want.green) begin
               $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
               mismatch_count++;
            end
            if (got.blue !== want.blue) begin
               $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
               mismatch_count++;
            end
         end
      end
   end

   // receiver: random stall bursts, plus one long hold on request
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_output) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles - 1) @(negedge clock);
            hold_output = 1'b0;
         end else if (receiver_idling && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timed out after %0d cycles", $time, cycle_count);
      $display("tb_hsv_to_rgb_converter_core: errors");
      $finish;
   end

   initial begin
      int row;
      int n;
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      pixels_sent     = 0;
      pixels_checked  = 0;
      mismatch_count  = 0;
      sender_idling   = 1'b1;
      receiver_idling = 1'b1;
      hold_output     = 1'b0;

      // hue, sat, value, typed, {blue, green, red}
      corner_rows = '{
         '{9'd0,   7'd100, 7'd100, 1'b1, '{8'd0,   8'd0,   8'd255}},
         '{9'd120, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd0}},
         '{9'd240, 7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd0}},
         '{9'd0,   7'd0,   7'd100, 1'b1, '{8'd255, 8'd255, 8'd255}},
         '{9'd200, 7'd50,  7'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
         '{9'd0,   7'd127, 7'd127, 1'b1, '{8'd0,   8'd0,   8'd255}},
         '{9'd360, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd0,   8'd255}},
         '{9'd480, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd0}},
         '{9'd60,  7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd255}},
         '{9'd180, 7'd100, 7'd100, 1'b1, '{8'd255, 8'd255, 8'd0}},
         '{9'd300, 7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd255}},
         '{9'd0,   7'd0,   7'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
         '{9'd1,   7'd0,   7'd127, 1'b1, '{8'd255, 8'd255, 8'd255}},
         '{9'd511, 7'd100, 7'd100, 1'b0, '0},
         '{9'd359, 7'd100, 7'd100, 1'b0, '0},
         '{9'd30,  7'd80,  7'd50,  1'b0, '0},
         '{9'd90,  7'd25,  7'd75,  1'b0, '0},
         '{9'd150, 7'd60,  7'd101, 1'b0, '0},
         '{9'd210, 7'd101, 7'd60,  1'b0, '0},
         '{9'd270, 7'd33,  7'd99,  1'b0, '0},
         '{9'd330, 7'd70,  7'd40,  1'b0, '0},
         '{9'd59,  7'd1,   7'd1,   1'b0, '0},
         '{9'd399, 7'd100, 7'd127, 1'b0, '0}
      };

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (row = 0; row < CornerRows; row++) begin
         send_pixel(corner_rows[row].hue, corner_rows[row].sat, corner_rows[row].bri,
                    corner_rows[row].typed, corner_rows[row].rgb);
      end

      // long output hold while input keeps coming, so the pipe backs up
      sender_idling = 1'b0;
      hold_output   = 1'b1;
      for (n = 0; n < StallItems; n++) send_random_pixel();
      req_tvalid <= 1'b0;
      while (pending_rgb.size() != 0) @(negedge clock);

      for (n = 0; n < RandomItems; n++) begin
         if (n % 64 == 0) begin
            sender_idling   = ($urandom_range(0, 3) != 0);
            receiver_idling = ($urandom_range(0, 3) != 0);
         end
         send_random_pixel();
      end

      // full-rate tail
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      for (n = 0; n < QuietItems; n++) send_random_pixel();
      req_tvalid <= 1'b0;

      while (pending_rgb.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("%0d pixels sent, %0d results checked, %0d mismatches",
               pixels_sent, pixels_checked, mismatch_count);
      $display("covered corner colours, hue wrap, percent saturation, long output hold");
      if (mismatch_count == 0) begin
         $display("tb_hsv_to_rgb_converter_core: clean");
      end else begin
         $display("tb_hsv_to_rgb_converter_core: errors");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/hsv2rgb_pkg.sv
sv/hsv_to_rgb_converter_core.sv
tb/tb_hsv_to_rgb_converter_core.sv
